// ===== sv/irat_pkg.sv =====
// ----------------------------------------------------------------------------
// irat_pkg - interval range-assign table shared definitions
// Request and status codes, and the operations that a breakpoint cell takes.
// ----------------------------------------------------------------------------
package irat_pkg;

  localparam logic REQ_ASSIGN = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Operation applied by every cell of the row in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,  // keep contents
    CELL_ROT  = 2'd1,  // rotate the whole row towards cell 0
    CELL_DEL  = 2'd2,  // close the slot at pos, cells above move down
    CELL_INS  = 2'd3   // open a slot at pos and write the new entry there
  } irat_op_t;

endpackage

// ===== sv/irat_if.sv =====
// ----------------------------------------------------------------------------
// irat_if - channel interfaces of the interval range-assign table
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface irat_req_if #(
  parameter int KB = 16,
  parameter int VB = 8
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [KB-1:0] key_low;
  logic [KB-1:0] key_high;
  logic [VB-1:0] new_value;
  modport source (output valid, req_type, key_low, key_high, new_value, input ready);
  modport sink   (input valid, req_type, key_low, key_high, new_value, output ready);
endinterface

interface irat_rsp_if #(
  parameter int VB = 8
);
  logic          valid;
  logic          ready;
  logic [VB-1:0] read_value;
  logic          status;
  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface irat_cfg_if #(
  parameter int VB = 8
);
  logic          valid;
  logic          ready;
  logic [VB-1:0] wdata;
  modport source (output valid, wdata, input ready);
  modport sink   (input valid, wdata, output ready);
endinterface

// ===== sv/irat_cell.sv =====
// ----------------------------------------------------------------------------
// irat_cell - one breakpoint slot of the table row
// Holds key, value and occupancy; rotates, closes or opens a slot on command.
// ----------------------------------------------------------------------------
module irat_cell
  import irat_pkg::*;
#(
  parameter int KB   = 16,
  parameter int VB   = 8,
  parameter int CW   = 7,
  parameter int IDX  = 0,
  parameter bit LAST = 1'b0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  irat_op_t      op,
  input  logic [CW-1:0] pos,
  input  logic [KB-1:0] ins_key,
  input  logic [VB-1:0] ins_val,
  input  logic          rt_occ,
  input  logic [KB-1:0] rt_key,
  input  logic [VB-1:0] rt_val,
  input  logic          lt_occ,
  input  logic [KB-1:0] lt_key,
  input  logic [VB-1:0] lt_val,
  output logic          occ,
  output logic [KB-1:0] key,
  output logic [VB-1:0] val
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic          occ_r, occ_nxt;
  logic [KB-1:0] key_r, key_nxt;
  logic [VB-1:0] val_r, val_nxt;

  always_comb begin
    occ_nxt = occ_r;
    key_nxt = key_r;
    val_nxt = val_r;
    case (op)
      CELL_ROT: begin
        occ_nxt = rt_occ;
        key_nxt = rt_key;
        val_nxt = rt_val;
      end
      CELL_DEL: begin
        if (MY_IDX >= pos) begin
          occ_nxt = LAST ? 1'b0 : rt_occ;
          key_nxt = rt_key;
          val_nxt = rt_val;
        end
      end
      CELL_INS: begin
        if (MY_IDX == pos) begin
          occ_nxt = 1'b1;
          key_nxt = ins_key;
          val_nxt = ins_val;
        end else if (MY_IDX > pos) begin
          occ_nxt = lt_occ;
          key_nxt = lt_key;
          val_nxt = lt_val;
        end
      end
      default: begin
        occ_nxt = occ_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign occ = occ_r;
  assign key = key_r;
  assign val = val_r;

endmodule

// ===== sv/interval_range_assign_table.sv =====
// ----------------------------------------------------------------------------
// interval_range_assign_table - sorted breakpoint table with range assign
// Row of breakpoint cells, a scan unit at cell 0 and an edit sequencer.
// ----------------------------------------------------------------------------
// Use: in_chan takes one request item (assign range or look up key), out_chan
// returns exactly one result item per request, in order. cfg_chan writes the
// default value; write it only while no request is in flight.
// A lookup rotates the whole row of CAPACITY cells past cell 0, then answers.
// An assign does the same scan, decides in ST_DECIDE until its insert flags
// settle, then takes one ST_DEL step per removed breakpoint and one ST_INS
// step per added breakpoint. An empty assign range skips the scan and goes
// straight to the response.
// A finished result sits in an output register; a new request is taken while
// it waits, but the next result waits in turn until out_chan takes the first.
// Reset empties the table (all cells unoccupied) and sets the default to 0.
// ----------------------------------------------------------------------------
module interval_range_assign_table
  import irat_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  irat_req_if.sink               in_chan,
  irat_rsp_if.source             out_chan,
  irat_cfg_if.sink               cfg_chan
);

  localparam int KB = KEY_BITS;
  localparam int VB = VALUE_BITS;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW:0]   CAP_W    = (CW + 1)'(CAPACITY);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_DEL    = 6'b001000,
    ST_INS    = 6'b010000,
    ST_RESP   = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [VB-1:0] dflt_r, dflt_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          req_r, req_nxt;
  logic [KB-1:0] lo_r, lo_nxt;
  logic [KB-1:0] hi_r, hi_nxt;
  logic [VB-1:0] nv_r, nv_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [VB-1:0] rv_r, rv_nxt;
  logic [VB-1:0] bef_r, bef_nxt;
  logic [VB-1:0] endv_r, endv_nxt;
  logic [CW-1:0] f_r, f_nxt;
  logic [CW-1:0] pe_r, pe_nxt;
  logic [CW-1:0] del_r, del_nxt;
  logic          put_lo_r, put_lo_nxt;
  logic          put_hi_r, put_hi_nxt;
  logic          full_r, full_nxt;
  logic          ov_r, ov_nxt;
  logic [VB-1:0] ord_r, ord_nxt;
  logic          ost_r, ost_nxt;

  irat_op_t      op;
  logic [KB-1:0] ins_key;
  logic [VB-1:0] ins_val;
  logic [CW-1:0] r_cnt;
  logic [CW:0]   total;
  logic          in_fire;

  logic          occ_a [CAPACITY];
  logic [KB-1:0] key_a [CAPACITY];
  logic [VB-1:0] val_a [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int RT = (i == CAPACITY - 1) ? 0 : i + 1;
    localparam int LT = (i == 0) ? 0 : i - 1;
    irat_cell #(
      .KB(KB), .VB(VB), .CW(CW), .IDX(i), .LAST(i == CAPACITY - 1)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .pos     (f_r),
      .ins_key (ins_key),
      .ins_val (ins_val),
      .rt_occ  (occ_a[RT]),
      .rt_key  (key_a[RT]),
      .rt_val  (val_a[RT]),
      .lt_occ  (occ_a[LT]),
      .lt_key  (key_a[LT]),
      .lt_val  (val_a[LT]),
      .occ     (occ_a[i]),
      .key     (key_a[i]),
      .val     (val_a[i])
    );
  end

  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid      = ov_r;
  assign out_chan.read_value = ord_r;
  assign out_chan.status     = ost_r;

  assign r_cnt   = pe_r - f_r;
  assign total   = {1'b0, count_r} - {1'b0, r_cnt}
                 + (CW + 1)'(put_lo_r) + (CW + 1)'(put_hi_r);
  // hi goes in first, then lo in front of it
  assign ins_key = put_hi_r ? hi_r : lo_r;
  assign ins_val = put_hi_r ? endv_r : nv_r;

  always_comb begin
    state_nxt  = state_r;
    dflt_nxt   = dflt_r;
    count_nxt  = count_r;
    req_nxt    = req_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    nv_nxt     = nv_r;
    scan_nxt   = scan_r;
    rv_nxt     = rv_r;
    bef_nxt    = bef_r;
    endv_nxt   = endv_r;
    f_nxt      = f_r;
    pe_nxt     = pe_r;
    del_nxt    = del_r;
    put_lo_nxt = put_lo_r;
    put_hi_nxt = put_hi_r;
    full_nxt   = full_r;
    ov_nxt     = ov_r;
    ord_nxt    = ord_r;
    ost_nxt    = ost_r;
    op         = CELL_HOLD;

    if (cfg_chan.valid) begin
      dflt_nxt = cfg_chan.wdata;
    end
    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt  = in_chan.req_type;
          lo_nxt   = in_chan.key_low;
          hi_nxt   = in_chan.key_high;
          nv_nxt   = in_chan.new_value;
          scan_nxt = '0;
          rv_nxt   = dflt_r;
          bef_nxt  = dflt_r;
          endv_nxt = dflt_r;
          f_nxt    = '0;
          pe_nxt   = '0;
          full_nxt = 1'b0;
          if (in_chan.req_type == REQ_ASSIGN && !(in_chan.key_low < in_chan.key_high)) begin
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        op       = CELL_ROT;
        scan_nxt = scan_r + 1'b1;
        if (occ_a[0]) begin
          if (req_r == REQ_LOOKUP) begin
            if (key_a[0] <= lo_r) rv_nxt = val_a[0];
          end else begin
            if (key_a[0] < lo_r) begin
              bef_nxt = val_a[0];
              f_nxt   = CW'(scan_r) + 1'b1;
            end
            if (key_a[0] <= hi_r) begin
              endv_nxt = val_a[0];
              pe_nxt   = CW'(scan_r) + 1'b1;
            end
          end
        end
        if (scan_r == LAST_IDX) begin
          state_nxt = (req_r == REQ_LOOKUP) ? ST_RESP : ST_DECIDE;
        end
        put_lo_nxt = 1'b0;
        put_hi_nxt = 1'b0;
      end
      ST_DECIDE: begin
        put_lo_nxt = (bef_r != nv_r);
        put_hi_nxt = (endv_r != nv_r);
        state_nxt  = ST_DECIDE;
        if (put_lo_r == (bef_r != nv_r) && put_hi_r == (endv_r != nv_r)) begin
          // flags are settled in their registers, total is now valid
          if (total > CAP_W) begin
            full_nxt   = 1'b1;
            put_lo_nxt = 1'b0;
            put_hi_nxt = 1'b0;
            state_nxt  = ST_RESP;
          end else begin
            count_nxt = total[CW-1:0];
            del_nxt   = r_cnt;
            if (r_cnt != '0) begin
              state_nxt = ST_DEL;
            end else if (put_lo_r || put_hi_r) begin
              state_nxt = ST_INS;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        end
      end
      ST_DEL: begin
        op      = CELL_DEL;
        del_nxt = del_r - 1'b1;
        if (del_r == CW'(1)) begin
          state_nxt = (put_lo_r || put_hi_r) ? ST_INS : ST_RESP;
        end
      end
      ST_INS: begin
        op = CELL_INS;
        if (put_hi_r) begin
          put_hi_nxt = 1'b0;
          if (!put_lo_r) state_nxt = ST_RESP;
        end else begin
          put_lo_nxt = 1'b0;
          state_nxt  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!ov_r || out_chan.ready) begin
          ov_nxt    = 1'b1;
          ord_nxt   = (req_r == REQ_LOOKUP) ? rv_r : '0;
          ost_nxt   = full_r ? STATUS_FULL : STATUS_DONE;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dflt_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dflt_r  <= dflt_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    nv_r     <= nv_nxt;
    scan_r   <= scan_nxt;
    rv_r     <= rv_nxt;
    bef_r    <= bef_nxt;
    endv_r   <= endv_nxt;
    f_r      <= f_nxt;
    pe_r     <= pe_nxt;
    del_r    <= del_nxt;
    put_lo_r <= put_lo_nxt;
    put_hi_r <= put_hi_nxt;
    full_r   <= full_nxt;
    ord_r    <= ord_nxt;
    ost_r    <= ost_nxt;
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= CAP_W) else $error("breakpoint count above capacity");
  a_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (occ_a[0] == (count_r != '0)))
    else $error("cell 0 occupancy disagrees with count");
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE)) else $error("request taken but sequencer idle");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r == ST_RESP)) else $error("result raised outside response");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - interval range-assign table
// Drives assign and lookup items with random idling and back-pressure,
// keeps its own breakpoint table to predict every result, and compares each
// result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import irat_pkg::*;

  localparam int CAP = 64;
  localparam int KB  = 16;
  localparam int VB  = 8;

  typedef struct packed {
    logic [VB-1:0] read_value;
    logic          status;
  } irat_result_t;

  class range_table_board;
    logic [KB-1:0] bp_key[CAP];
    logic [VB-1:0] bp_val[CAP];
    int            bp_cnt;
    logic [VB-1:0] dflt;
    irat_result_t  pending[$];
    int            mismatches;

    function void clear();
      bp_cnt = 0;
      dflt = '0;
      mismatches = 0;
      pending.delete();
    endfunction

    function logic [VB-1:0] value_of(logic [KB-1:0] key);
      logic [VB-1:0] v;
      v = dflt;
      for (int i = 0; i < bp_cnt; i++) begin
        if (bp_key[i] > key) break;
        v = bp_val[i];
      end
      return v;
    endfunction

    // returns STATUS_FULL when the edit would overflow the table
    function logic assign_range(logic [KB-1:0] lo, logic [KB-1:0] hi, logic [VB-1:0] v);
      logic [KB-1:0] nk[CAP];
      logic [VB-1:0] nv[CAP];
      logic [VB-1:0] before_v, end_v;
      int first_in, past_end, n;
      bit put_lo, put_hi;
      if (!(lo < hi)) return STATUS_DONE;
      before_v = dflt;
      first_in = 0;
      while (first_in < bp_cnt && bp_key[first_in] < lo) begin
        before_v = bp_val[first_in];
        first_in++;
      end
      end_v = before_v;
      past_end = first_in;
      while (past_end < bp_cnt && bp_key[past_end] <= hi) begin
        end_v = bp_val[past_end];
        past_end++;
      end
      put_lo = (before_v != v);
      put_hi = (end_v != v);
      if (bp_cnt - (past_end - first_in) + put_lo + put_hi > CAP) return STATUS_FULL;
      n = 0;
      for (int i = 0; i < first_in; i++) begin
        nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
      end
      if (put_lo) begin
        nk[n] = lo; nv[n] = v; n++;
      end
      if (put_hi) begin
        nk[n] = hi; nv[n] = end_v; n++;
      end
      for (int i = past_end; i < bp_cnt; i++) begin
        nk[n] = bp_key[i]; nv[n] = bp_val[i]; n++;
      end
      for (int i = 0; i < n; i++) begin
        bp_key[i] = nk[i]; bp_val[i] = nv[i];
      end
      bp_cnt = n;
      return STATUS_DONE;
    endfunction

    function void note_request(logic rt, logic [KB-1:0] lo, logic [KB-1:0] hi,
                               logic [VB-1:0] v);
      irat_result_t r;
      if (rt == REQ_LOOKUP) begin
        r.read_value = value_of(lo);
        r.status = STATUS_DONE;
      end else begin
        r.read_value = '0;
        r.status = assign_range(lo, hi, v);
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [VB-1:0] rv, logic st);
      irat_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value %0d status %0d", rv, st);
        return;
      end
      e = pending.pop_front();
      if (rv !== e.read_value || st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected value %0d status %0d, got value %0d status %0d",
                   e.read_value, e.status, rv, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  irat_req_if #(.KB(KB), .VB(VB)) req_i ();
  irat_rsp_if #(.VB(VB)) rsp_i ();
  irat_cfg_if #(.VB(VB)) cfg_i ();

  interval_range_assign_table #(
    .CAPACITY(CAP), .KEY_BITS(KB), .VALUE_BITS(VB)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(req_i), .out_chan(rsp_i), .cfg_chan(cfg_i)
  );

  range_table_board board;
  int  idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
  bit  hold_req;
  int  hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

  // note each accepted item, then check results
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_i.valid && req_i.ready)
        board.note_request(req_i.req_type, req_i.key_low, req_i.key_high, req_i.new_value);
      if (rsp_i.valid && rsp_i.ready) board.check_result(rsp_i.read_value, rsp_i.status);
    end
  end

  // receiver: random stalls by phase, plus a long hold-off on request
  initial begin
    int stall_pct;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_i.ready <= 1'b0;
      end else begin
        stall_pct = (idle_mode == 2) ? 56 : (idle_mode == 3) ? 16 : 0;
        rsp_i.ready <= (int'($urandom_range(99)) >= stall_pct);
      end
    end
  end

  task automatic send_item(logic rt, logic [KB-1:0] lo, logic [KB-1:0] hi,
                           logic [VB-1:0] v);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 16 : 0;
    if (int'($urandom_range(99)) < gap_pct) begin
      req_i.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req_i.valid <= 1'b1;
    req_i.req_type <= rt;
    req_i.key_low <= lo;
    req_i.key_high <= hi;
    req_i.new_value <= v;
    do @(posedge clk); while (!(req_i.valid && req_i.ready));
  endtask

  task automatic drain();
    req_i.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() > 0) @(posedge clk);
  endtask

  task automatic write_default(logic [VB-1:0] d);
    drain();
    repeat (4) @(posedge clk);
    cfg_i.valid <= 1'b1;
    cfg_i.wdata <= d;
    do @(posedge clk); while (!cfg_i.ready);
    cfg_i.valid <= 1'b0;
    board.dflt = d;
  endtask

  task automatic random_item();
    logic [KB-1:0] lo, hi;
    logic [VB-1:0] v;
    int w;
    w = $urandom_range(99);
    if (w < 80) begin
      // narrow window so that ranges overlap and the table gets edited
      lo = KB'($urandom_range(255));
      hi = KB'(lo + $urandom_range(40) - 4);
    end else begin
      lo = KB'($urandom);
      hi = KB'($urandom);
    end
    v = ($urandom_range(3) == 0) ? VB'($urandom) : VB'($urandom_range(3));
    if ($urandom_range(99) < 35) send_item(REQ_LOOKUP, lo, KB'($urandom), VB'($urandom));
    else if ($urandom_range(99) < 3) send_item(REQ_ASSIGN, '0, 16'hffff, v);
    else send_item(REQ_ASSIGN, lo, hi, v);
  endtask

  initial begin
    bit failed;
    board = new();
    board.clear();
    idle_mode = 0;
    hold_req = 0;
    hold_cnt = 0;
    rst_n = 1'b0;
    req_i.valid = 1'b0; req_i.req_type = REQ_ASSIGN;
    req_i.key_low = '0; req_i.key_high = '0; req_i.new_value = '0;
    rsp_i.ready = 1'b0;
    cfg_i.valid = 1'b0; cfg_i.wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(REQ_LOOKUP, 16'h0000, '0, '0);
    send_item(REQ_LOOKUP, 16'hffff, '0, '0);
    send_item(REQ_ASSIGN, 16'd100, 16'd100, 8'hff);   // empty range
    send_item(REQ_ASSIGN, 16'd200, 16'd100, 8'h55);   // reversed, also empty
    send_item(REQ_ASSIGN, 16'h0000, 16'hffff, 8'hff);
    send_item(REQ_LOOKUP, 16'h0000, '0, '0);
    send_item(REQ_LOOKUP, 16'hfffe, '0, '0);
    send_item(REQ_LOOKUP, 16'hffff, '0, '0);
    send_item(REQ_ASSIGN, 16'h8000, 16'hffff, 8'h00);
    send_item(REQ_ASSIGN, 16'h0000, 16'hffff, 8'h00); // back to default
    for (int i = 0; i < 32; i++) send_item(REQ_ASSIGN, KB'(4 * i), KB'(4 * i + 2), 8'haa);
    send_item(REQ_ASSIGN, 16'd1000, 16'd1001, 8'h01); // overflow
    send_item(REQ_ASSIGN, 16'd1, 16'd2, 8'haa);       // inside a run, no change
    send_item(REQ_LOOKUP, 16'd126, '0, '0);
    send_item(REQ_LOOKUP, 16'd127, '0, '0);
    write_default(8'haa);                     // first entry now equals default
    send_item(REQ_LOOKUP, 16'hffff, '0, '0);
    send_item(REQ_ASSIGN, 16'h0000, 16'hffff, 8'haa);
    send_item(REQ_LOOKUP, 16'd300, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_default(8'h00);
        1: write_default(8'hff);
        2: write_default(VB'($urandom_range(3)));
        default: write_default(VB'($urandom));
      endcase
      idle_mode = ph;
      for (int n = 0; n < 480; n++) begin
        if (ph == 1 && n == 10) hold_req = 1'b1;
        if (ph == 2 && n == 200) drain();
        random_item();
      end
    end

    drain();
    repeat (2 * CAP + 20) @(posedge clk);
    failed = (board.mismatches > 0) || (board.pending.size() > 0);
    if (!failed) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
sv/irat_pkg.sv
sv/irat_if.sv
sv/irat_cell.sv
sv/interval_range_assign_table.sv
verif/testbench.sv
